>>> sv/gray_threshold_bounding_box_top_macros.svh
// Assertion macros for the gray threshold bounding box block.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef GRAY_THRESHOLD_BOUNDING_BOX_TOP_MACROS_SVH
`define GRAY_THRESHOLD_BOUNDING_BOX_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GTBB_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gtbb check failed");

// antecedent implies consequent in the next cycle
`define GTBB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gtbb check failed");

`endif

>>> sv/gtbb_pkg.sv
// Package for the gray threshold bounding box block.
// Payload structs, queue entry types and register constants; no dependencies.
package gtbb_pkg;

	localparam int CNT_W = 12;
	localparam int LW_W  = 13;

	localparam logic [LW_W-1:0] LINE_WIDTH_RST    = 13'd640;
	localparam logic [7:0]      DARK_THRESHOLD_RST = 8'd128;

	localparam logic [7:0] MONO_BLACK = 8'd0;
	localparam logic [7:0] MONO_WHITE = 8'd255;

	// register index, taken from paddr[2]
	localparam logic REG_LINE_WIDTH     = 1'b0;
	localparam logic REG_DARK_THRESHOLD = 1'b1;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic       frame_last;
	} pix_t;

	typedef struct packed {
		logic [7:0]       mono_pixel;
		logic             box_valid;
		logic             box_found;
		logic [CNT_W-1:0] box_left;
		logic [CNT_W-1:0] box_top;
		logic [CNT_W-1:0] box_right;
		logic [CNT_W-1:0] box_bottom;
	} res_t;

	typedef struct packed {
		logic             dark;
		logic             last;
		logic [CNT_W-1:0] x;
		logic [CNT_W-1:0] y;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} q_port_t;

endpackage

>>> sv/gtbb_front.sv
// Front end: threshold of the RGB average and column/row position.
// Depends on gtbb_pkg; pushes classified pixels into gtbb_queue.
module gtbb_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pix_valid,
	output logic                       pix_stall,
	input  gtbb_pkg::pix_t             pix,
	input  logic [gtbb_pkg::LW_W-1:0]  line_width,
	input  logic [7:0]                 dark_threshold,
	input  logic                       q_full,
	output gtbb_pkg::q_port_t          q_wr
);

	localparam int CW = gtbb_pkg::CNT_W;
	localparam logic [CW-1:0] COL_CAP = (MAX_WIDTH < (1 << CW)) ?
		CW'(MAX_WIDTH - 1) : {CW{1'b1}};
	localparam logic [CW-1:0] ROW_CAP = (MAX_HEIGHT < (1 << CW)) ?
		CW'(MAX_HEIGHT - 1) : {CW{1'b1}};

	logic [CW-1:0] x_q, y_q;
	logic [9:0]    sum;
	logic [9:0]    limit;
	logic          dark;
	logic          accept;
	logic          wrap;

	// floor(sum/3) < t  <=>  sum < 3t
	assign sum    = 10'(pix.red_in) + 10'(pix.green_in) + 10'(pix.blue_in);
	assign limit  = {1'b0, dark_threshold, 1'b0} + 10'(dark_threshold);
	assign dark   = sum < limit;
	assign accept = pix_valid && !q_full;
	assign wrap   = (({1'b0, x_q} + 13'd1) == line_width) || (x_q >= COL_CAP);

	assign pix_stall = q_full;

	always_comb begin
		q_wr.valid      = accept;
		q_wr.entry.dark = dark;
		q_wr.entry.last = pix.frame_last;
		q_wr.entry.x    = x_q;
		q_wr.entry.y    = y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (accept) begin
			if (pix.frame_last) begin
				x_q <= '0;
				y_q <= '0;
			end else if (wrap) begin
				x_q <= '0;
				if (y_q < ROW_CAP) begin
					y_q <= y_q + CW'(1);
				end
			end else begin
				x_q <= x_q + CW'(1);
			end
		end
	end

endmodule

>>> sv/gtbb_queue.sv
// Two-entry queue between front and back ends.
// Depends on gtbb_pkg; push and pop may occur in the same cycle.
module gtbb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  gtbb_pkg::q_port_t q_wr,
	output logic              full,
	input  logic              pop,
	output gtbb_pkg::q_port_t q_rd
);

	gtbb_pkg::entry_t mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;

	assign full          = count_q == 2'd2;
	assign q_rd.valid    = count_q != 2'd0;
	assign q_rd.entry    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_wr.valid) begin
			mem_q[wr_ptr_q] <= q_wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (q_wr.valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (q_wr.valid && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (!q_wr.valid && pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> sv/gtbb_back.sv
// Back end: bounding box tracking and the result register.
// Depends on gtbb_pkg; pops classified pixels from gtbb_queue.
module gtbb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  gtbb_pkg::q_port_t q_rd,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_stall,
	output gtbb_pkg::res_t    res
);

	localparam int CW = gtbb_pkg::CNT_W;

	logic [CW-1:0]  left_q, top_q, right_q, bottom_q;
	logic           seen_q, prev_q;
	logic [CW-1:0]  left_d, top_d, right_d, bottom_d;
	logic           seen_d, prev_d;
	logic           valid_q;
	gtbb_pkg::res_t res_q;
	gtbb_pkg::res_t res_d;
	gtbb_pkg::entry_t e;

	assign e         = q_rd.entry;
	assign pop       = q_rd.valid && (!valid_q || !res_stall);
	assign res_valid = valid_q;
	assign res       = res_q;

	always_comb begin
		left_d   = left_q;
		top_d    = top_q;
		right_d  = right_q;
		bottom_d = bottom_q;
		seen_d   = seen_q;
		prev_d   = prev_q;
		if (e.dark) begin
			if (!seen_q || e.x < left_q) begin
				left_d = e.x;
			end
			if (!seen_q) begin
				top_d = e.y;
			end
			seen_d   = 1'b1;
			bottom_d = e.y;
			prev_d   = 1'b1;
		end else begin
			if (prev_q && e.x > right_q) begin
				right_d = e.x;
			end
			prev_d = 1'b0;
		end

		res_d            = '0;
		res_d.mono_pixel = e.dark ? gtbb_pkg::MONO_BLACK : gtbb_pkg::MONO_WHITE;
		if (e.last) begin
			res_d.box_valid = 1'b1;
			res_d.box_found = seen_d;
			if (seen_d) begin
				res_d.box_left   = left_d;
				res_d.box_top    = top_d;
				res_d.box_right  = right_d;
				res_d.box_bottom = bottom_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			left_q   <= '0;
			top_q    <= '0;
			right_q  <= '0;
			bottom_q <= '0;
			seen_q   <= 1'b0;
			prev_q   <= 1'b0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
			end else if (!res_stall) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				if (e.last) begin
					left_q   <= '0;
					top_q    <= '0;
					right_q  <= '0;
					bottom_q <= '0;
					seen_q   <= 1'b0;
					prev_q   <= 1'b0;
				end else begin
					left_q   <= left_d;
					top_q    <= top_d;
					right_q  <= right_d;
					bottom_q <= bottom_d;
					seen_q   <= seen_d;
					prev_q   <= prev_d;
				end
			end
		end
	end

endmodule

>>> sv/gray_threshold_bounding_box_top.sv
// An accepted pixel is written into the queue, then popped into the result register.
// Throughput: one pixel per clock; the front end stalls only when the
// two-entry queue is full, which happens only after the result side has stalled.
// Reset: counters, box state and queue clear; line_width goes to 640 and
// dark_threshold to 128. No clearing pass.
// Top level: APB registers, gtbb_front, gtbb_queue and gtbb_back; uses gtbb_pkg.
module gray_threshold_bounding_box_top #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	input  logic            pix_valid,
	output logic            pix_stall,
	input  gtbb_pkg::pix_t  pix,
	output logic            res_valid,
	input  logic            res_stall,
	output gtbb_pkg::res_t  res
);

	logic [gtbb_pkg::LW_W-1:0] line_width_q;
	logic [7:0]                dark_threshold_q;
	logic                      wr_en;
	gtbb_pkg::q_port_t         q_wr, q_rd;
	logic                      q_full, q_pop;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q     <= gtbb_pkg::LINE_WIDTH_RST;
			dark_threshold_q <= gtbb_pkg::DARK_THRESHOLD_RST;
		end else if (wr_en) begin
			case (paddr[2])
				gtbb_pkg::REG_LINE_WIDTH: begin
					line_width_q <= pwdata[gtbb_pkg::LW_W-1:0];
				end
				gtbb_pkg::REG_DARK_THRESHOLD: begin
					dark_threshold_q <= pwdata[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			gtbb_pkg::REG_LINE_WIDTH:     prdata = 32'(line_width_q);
			gtbb_pkg::REG_DARK_THRESHOLD: prdata = 32'(dark_threshold_q);
			default:                      prdata = '0;
		endcase
	end

	gtbb_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix_valid     (pix_valid),
		.pix_stall     (pix_stall),
		.pix           (pix),
		.line_width    (line_width_q),
		.dark_threshold(dark_threshold_q),
		.q_full        (q_full),
		.q_wr          (q_wr)
	);

	gtbb_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.q_wr  (q_wr),
		.full  (q_full),
		.pop   (q_pop),
		.q_rd  (q_rd)
	);

	gtbb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rd     (q_rd),
		.pop      (q_pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule

>>> sv/gtbb_checker.sv
// Port-level checker for gray_threshold_bounding_box_top, bound to it below.
// Depends on gtbb_pkg and the macro header.
`include "gray_threshold_bounding_box_top_macros.svh"

module gtbb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_stall,
	input gtbb_pkg::res_t res
);

	`GTBB_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))
	`GTBB_ASSERT_SAME(a_mono_code, res_valid, res.mono_pixel == gtbb_pkg::MONO_BLACK || res.mono_pixel == gtbb_pkg::MONO_WHITE)
	`GTBB_ASSERT_SAME(a_mid_frame, res_valid && !res.box_valid, !res.box_found && res.box_left == '0 && res.box_right == '0)
	`GTBB_ASSERT_SAME(a_empty_box, res_valid && !res.box_found, res.box_top == '0 && res.box_bottom == '0)

endmodule

bind gray_threshold_bounding_box_top gtbb_checker u_gtbb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res      (res)
);

>>> test/tb.sv
// Self-checking testbench for gray_threshold_bounding_box_top.
// Drives RGB pixel transactions and APB register writes, predicts mono pixels
// and the dark-pixel box in-line; depends on gtbb_pkg and the top level only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W = 4096;
	localparam int MAX_H = 4096;
	localparam logic [gtbb_pkg::CNT_W-1:0] COL_CAP =
		gtbb_pkg::CNT_W'((MAX_W < 4096) ? MAX_W - 1 : 4095);
	localparam logic [gtbb_pkg::CNT_W-1:0] ROW_CAP =
		gtbb_pkg::CNT_W'((MAX_H < 4096) ? MAX_H - 1 : 4095);
	localparam int LIMIT = 400000;
	localparam int NUM_DIR = 27;

	typedef enum logic [1:0] {ROW_PIX, ROW_CHECK, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	typedef struct packed {
		row_kind_t                 kind;
		logic [gtbb_pkg::LW_W-1:0] lw;
		logic [7:0]                thr;
		gtbb_pkg::pix_t            px;
		gtbb_pkg::res_t            want;
	} dir_row_t;

	localparam gtbb_pkg::res_t NO_RES = '0;
	localparam logic [7:0] BLK = gtbb_pkg::MONO_BLACK;
	localparam logic [7:0] WHT = gtbb_pkg::MONO_WHITE;

	// directed transactions; ROW_CHECK rows carry a hand-computed result
	localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
		'{ROW_CHECK, 13'd0, 8'd0, '{8'd255, 8'd255, 8'd255, 1'b0},
			'{WHT, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0}},
		'{ROW_CHECK, 13'd0, 8'd0, '{8'd0, 8'd0, 8'd0, 1'b1},
			'{BLK, 1'b1, 1'b1, 12'd1, 12'd0, 12'd0, 12'd0}},
		// frame with no dark pixel
		'{ROW_CHECK, 13'd0, 8'd0, '{8'd255, 8'd255, 8'd255, 1'b1},
			'{WHT, 1'b1, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0}},
		// gray 127 / 128 around the reset threshold
		'{ROW_PIX, 13'd0, 8'd0, '{8'd127, 8'd127, 8'd128, 1'b0}, NO_RES},
		'{ROW_PIX, 13'd0, 8'd0, '{8'd127, 8'd128, 8'd129, 1'b0}, NO_RES},
		'{ROW_CHECK, 13'd0, 8'd0, '{8'd128, 8'd128, 8'd128, 1'b1},
			'{WHT, 1'b1, 1'b1, 12'd0, 12'd0, 12'd1, 12'd0}},
		// threshold 0: nothing is dark
		'{ROW_CFG, 13'd640, 8'd0, '0, NO_RES},
		'{ROW_CHECK, 13'd0, 8'd0, '{8'd0, 8'd0, 8'd0, 1'b1},
			'{WHT, 1'b1, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0}},
		// dark flag carried over a line end
		'{ROW_CFG, 13'd3, 8'd255, '0, NO_RES},
		'{ROW_PIX, 13'd0, 8'd0, '{8'd255, 8'd255, 8'd255, 1'b0}, NO_RES},
		'{ROW_PIX, 13'd0, 8'd0, '{8'd255, 8'd255, 8'd254, 1'b0}, NO_RES},
		'{ROW_PIX, 13'd0, 8'd0, '{8'd255, 8'd255, 8'd255, 1'b0}, NO_RES},
		'{ROW_PIX, 13'd0, 8'd0, '{8'd0, 8'd0, 8'd0, 1'b0}, NO_RES},
		'{ROW_PIX, 13'd0, 8'd0, '{8'd0, 8'd0, 8'd0, 1'b0}, NO_RES},
		'{ROW_PIX, 13'd0, 8'd0, '{8'd10, 8'd20, 8'd30, 1'b0}, NO_RES},
		'{ROW_PIX, 13'd0, 8'd0, '{8'd255, 8'd255, 8'd255, 1'b0}, NO_RES},
		'{ROW_PIX, 13'd0, 8'd0, '{8'd255, 8'd255, 8'd255, 1'b1}, NO_RES},
		// right edge left of the left edge
		'{ROW_PIX, 13'd0, 8'd0, '{8'd255, 8'd255, 8'd255, 1'b0}, NO_RES},
		'{ROW_PIX, 13'd0, 8'd0, '{8'd255, 8'd255, 8'd255, 1'b0}, NO_RES},
		'{ROW_CHECK, 13'd0, 8'd0, '{8'd0, 8'd0, 8'd0, 1'b1},
			'{BLK, 1'b1, 1'b1, 12'd2, 12'd0, 12'd0, 12'd0}},
		// one pixel per line
		'{ROW_CFG, 13'd1, 8'd128, '0, NO_RES},
		'{ROW_PIX, 13'd0, 8'd0, '{8'd0, 8'd0, 8'd0, 1'b0}, NO_RES},
		'{ROW_PIX, 13'd0, 8'd0, '{8'd255, 8'd255, 8'd255, 1'b0}, NO_RES},
		'{ROW_CHECK, 13'd0, 8'd0, '{8'd0, 8'd0, 8'd0, 1'b1},
			'{BLK, 1'b1, 1'b1, 12'd0, 12'd0, 12'd0, 12'd2}},
		'{ROW_CFG, 13'd4096, 8'd128, '0, NO_RES},
		'{ROW_PIX, 13'd0, 8'd0, '{8'd0, 8'd255, 8'd0, 1'b0}, NO_RES},
		'{ROW_PIX, 13'd0, 8'd0, '{8'd255, 8'd0, 8'd255, 1'b1}, NO_RES}
	};

	logic           clk;
	logic           arst_n = 1'b0;
	logic           psel = 1'b0;
	logic           penable = 1'b0;
	logic           pwrite = 1'b0;
	logic [2:0]     paddr = '0;
	logic [31:0]    pwdata = '0;
	logic [31:0]    prdata;
	logic           pready;
	logic           pix_valid = 1'b0;
	logic           pix_stall;
	gtbb_pkg::pix_t pix = '0;
	logic           res_valid;
	logic           res_stall = 1'b0;
	gtbb_pkg::res_t res;

	// predictor copy of configuration and tracking state
	logic [gtbb_pkg::LW_W-1:0]  cfg_lw = gtbb_pkg::LINE_WIDTH_RST;
	logic [7:0]                 cfg_thr = gtbb_pkg::DARK_THRESHOLD_RST;
	logic [gtbb_pkg::CNT_W-1:0] col_pos = '0;
	logic [gtbb_pkg::CNT_W-1:0] row_pos = '0;
	logic [gtbb_pkg::CNT_W-1:0] edge_l = '0;
	logic [gtbb_pkg::CNT_W-1:0] edge_t = '0;
	logic [gtbb_pkg::CNT_W-1:0] edge_r = '0;
	logic [gtbb_pkg::CNT_W-1:0] edge_b = '0;
	logic                       any_dark = 1'b0;
	logic                       prev_dark = 1'b0;

	gtbb_pkg::res_t predicted_mono[$];
	int             err_count = 0;
	int             cycle_count = 0;
	int             burst_left = 0;
	bit             steady = 1'b0;

	gray_threshold_bounding_box_top #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic gtbb_pkg::res_t binarize_track(gtbb_pkg::pix_t p);
		logic [9:0]     sum;
		logic [9:0]     gray;
		logic           dark;
		gtbb_pkg::res_t r;
		sum = 10'(p.red_in) + 10'(p.green_in) + 10'(p.blue_in);
		gray = sum / 10'd3;
		dark = gray < {2'b00, cfg_thr};
		r = '0;
		if (dark) begin
			if (!any_dark || col_pos < edge_l)
				edge_l = col_pos;
			if (!any_dark)
				edge_t = row_pos;
			any_dark = 1'b1;
			edge_b = row_pos;
			prev_dark = 1'b1;
		end else begin
			if (prev_dark && col_pos > edge_r)
				edge_r = col_pos;
			prev_dark = 1'b0;
		end
		r.mono_pixel = dark ? gtbb_pkg::MONO_BLACK : gtbb_pkg::MONO_WHITE;
		if (p.frame_last) begin
			r.box_valid = 1'b1;
			r.box_found = any_dark;
			if (any_dark) begin
				r.box_left = edge_l;
				r.box_top = edge_t;
				r.box_right = edge_r;
				r.box_bottom = edge_b;
			end
			col_pos = '0;
			row_pos = '0;
			edge_l = '0;
			edge_t = '0;
			edge_r = '0;
			edge_b = '0;
			any_dark = 1'b0;
			prev_dark = 1'b0;
		end else if ({1'b0, col_pos} + 13'd1 == cfg_lw || col_pos >= COL_CAP) begin
			col_pos = '0;
			if (row_pos < ROW_CAP)
				row_pos = row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
		return r;
	endfunction

	function automatic gtbb_pkg::pix_t random_pixel(int dens, logic [7:0] thr, logic last);
		gtbb_pkg::pix_t p;
		if ($urandom_range(0, 3) == 0) begin
			p.red_in = 8'($urandom);
			p.green_in = 8'($urandom);
			p.blue_in = 8'($urandom);
		end else if ($urandom_range(1, 100) <= dens && thr != 8'd0) begin
			p.red_in = 8'($urandom_range(0, thr - 1));
			p.green_in = 8'($urandom_range(0, thr - 1));
			p.blue_in = 8'($urandom_range(0, thr - 1));
		end else begin
			p.red_in = 8'($urandom_range(thr, 255));
			p.green_in = 8'($urandom_range(thr, 255));
			p.blue_in = 8'($urandom_range(thr, 255));
		end
		// occasional early frame end
		p.frame_last = last | ($urandom_range(0, 49) == 0);
		return p;
	endfunction

	task automatic report_field(string what, logic [31:0] want, logic [31:0] got);
		$display("%0t ERROR %s: expected %0d, got %0d", $time, what, want, got);
		err_count++;
	endtask

	task automatic push_pixel(gtbb_pkg::pix_t p, bit use_want = 1'b0,
			gtbb_pkg::res_t want = '0);
		gtbb_pkg::res_t r;
		pix <= p;
		pix_valid <= 1'b1;
		do @(posedge clk); while (pix_stall !== 1'b0);
		r = binarize_track(p);
		predicted_mono.push_back(use_want ? want : r);
		if (burst_left > 0) begin
			burst_left--;
		end else if (!steady) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(0, 24);
		end
	endtask

	task automatic drain();
		pix_valid <= 1'b0;
		while (predicted_mono.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_xfer(logic wr, logic reg_idx, logic [31:0] data,
			output logic [31:0] rdata);
		logic done;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {reg_idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdata = prdata;
			done = pready;
			@(posedge clk);
		end while (done !== 1'b1);
	endtask

	task automatic readback_config(logic [gtbb_pkg::LW_W-1:0] lw, logic [7:0] thr);
		logic [31:0] got;
		apb_xfer(1'b0, gtbb_pkg::REG_LINE_WIDTH, '0, got);
		if (got !== {19'd0, lw})
			report_field("line_width readback", {19'd0, lw}, got);
		apb_xfer(1'b0, gtbb_pkg::REG_DARK_THRESHOLD, '0, got);
		if (got !== {24'd0, thr})
			report_field("dark_threshold readback", {24'd0, thr}, got);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(logic [gtbb_pkg::LW_W-1:0] lw, logic [7:0] thr);
		logic [31:0] unused;
		apb_xfer(1'b1, gtbb_pkg::REG_LINE_WIDTH, {19'd0, lw}, unused);
		apb_xfer(1'b1, gtbb_pkg::REG_DARK_THRESHOLD, {24'd0, thr}, unused);
		cfg_lw = lw;
		cfg_thr = thr;
		readback_config(lw, thr);
	endtask

	always @(posedge clk) begin : result_side
		gtbb_pkg::res_t want;
		stall_mode_t    mode;
		cycle_count++;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (predicted_mono.size() == 0) begin
				$display("%0t ERROR unexpected transaction: expected none, got %h",
					$time, res);
				err_count++;
			end else begin
				want = predicted_mono.pop_front();
				if (res.mono_pixel !== want.mono_pixel)
					report_field("mono_pixel", 32'(want.mono_pixel),
						32'(res.mono_pixel));
				if (res.box_valid !== want.box_valid)
					report_field("box_valid", 32'(want.box_valid), 32'(res.box_valid));
				if (res.box_found !== want.box_found)
					report_field("box_found", 32'(want.box_found), 32'(res.box_found));
				if (res.box_left !== want.box_left)
					report_field("box_left", 32'(want.box_left), 32'(res.box_left));
				if (res.box_top !== want.box_top)
					report_field("box_top", 32'(want.box_top), 32'(res.box_top));
				if (res.box_right !== want.box_right)
					report_field("box_right", 32'(want.box_right), 32'(res.box_right));
				if (res.box_bottom !== want.box_bottom)
					report_field("box_bottom", 32'(want.box_bottom),
						32'(res.box_bottom));
			end
		end
		mode = stall_mode_t'((cycle_count / 300) % 4);
		case (mode)
			STALL_NONE: res_stall <= 1'b0;
			STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
			default: res_stall <= ((cycle_count % 7) < 3);
		endcase
	end

	initial begin : watchdog
		wait (cycle_count >= LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		dir_row_t                  row;
		logic [gtbb_pkg::LW_W-1:0] lw;
		logic [7:0]                thr;
		int                        n;
		int                        flen;
		int                        cap;
		int                        dens;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		readback_config(gtbb_pkg::LINE_WIDTH_RST, gtbb_pkg::DARK_THRESHOLD_RST);

		for (int i = 0; i < NUM_DIR; i++) begin
			row = DIR_ROWS[i];
			if (row.kind == ROW_CFG) begin
				drain();
				set_config(row.lw, row.thr);
			end else begin
				push_pixel(row.px, row.kind == ROW_CHECK, row.want);
			end
		end

		for (int ph = 0; ph < 12; ph++) begin
			drain();
			case ($urandom_range(0, 9))
				0: lw = 13'd1;
				1: lw = 13'd2;
				2: lw = 13'd4096;
				3: lw = 13'd8191;
				4: lw = 13'd640;
				default: lw = 13'($urandom_range(3, 16));
			endcase
			case ($urandom_range(0, 5))
				0: thr = 8'd0;
				1: thr = 8'd255;
				2: thr = 8'd128;
				default: thr = 8'($urandom);
			endcase
			set_config(lw, thr);
			steady = (ph % 4 == 3);
			cap = (lw == 13'd0 || lw > 13'd16) ? 40 : 3 * lw;
			n = 0;
			while (n < 115) begin
				flen = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, cap);
				dens = $urandom_range(0, 100);
				for (int f = 0; f < flen; f++)
					push_pixel(random_pixel(dens, thr, f == flen - 1));
				n += flen;
				// hold off mid-phase until everything is out
				if (ph == 5 && n == flen)
					drain();
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
